FILE: sv/uct_pkg.sv
package uct_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

  localparam logic [CFG_IDX_W-1:0] CFG_CASE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATIN5    = 1'b1;

  typedef enum logic [1:0] {
    CASE_KEEP  = 2'd0,
    CASE_LOWER = 2'd1,
    CASE_UPPER = 2'd2,
    CASE_FOLD  = 2'd3
  } case_mode_t;

  // One decoded code point on its way to the encoder.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            replaced;
    logic            eot;
    logic            last;
  } token_t;

endpackage

FILE: sv/utf8_case_transcoder.sv
// Streaming UTF-8 case mapper with Turkish rules. A byte enters each cycle
// while the short token queue between decoder and encoder has room; a
// rejected pending sequence first has the decoder drain its held bytes as
// stray tokens before the new byte is taken. The encoder sends one UTF-8
// byte per cycle from its output register unless out_ready stalls it, so a
// code point of k output bytes holds it until all k are sent: plain ASCII
// runs at one byte in and one byte out per cycle, and multi-byte results
// throttle the input through the queue. Configuration must be written by
// the user only while the block is idle; the block does not enforce it.
module utf8_case_transcoder #(
  parameter int QUEUE_DEPTH = uct_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [uct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_replaced,
  output logic                           out_end_of_text,
  output logic                           out_last_of_run
);

  uct_pkg::case_mode_t case_mode_r;
  logic                latin5_r;

  logic            push, q_full, q_pop, q_nonempty;
  uct_pkg::token_t push_tok, head_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r <= uct_pkg::CASE_LOWER;
      latin5_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        uct_pkg::CFG_CASE_MODE: case_mode_r <= uct_pkg::case_mode_t'(cfg_wdata[1:0]);
        uct_pkg::CFG_LATIN5:    latin5_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  uct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .latin5   (latin5_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  uct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_tok (head_tok)
  );

  uct_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .case_mode       (case_mode_r),
    .q_nonempty      (q_nonempty),
    .q_tok           (head_tok),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_replaced    (out_replaced),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: sv/uct_front.sv
module uct_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            latin5,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            push,
  output uct_pkg::token_t push_tok
);

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] hcnt_r, hcnt_nxt;

  logic [7:0]                 h0;
  logic [2:0]                 need;
  logic                       complete;
  logic [uct_pkg::CP_W-1:0]   cp;
  logic [uct_pkg::CP_W-1:0]   minv;
  logic                       bad;
  logic                       flush;
  logic                       b_cont;
  logic                       b_lead;

  function automatic logic [uct_pkg::CP_W-1:0] latin5_cp(input logic [7:0] b);
    logic [uct_pkg::CP_W-1:0] r;
    case (b)
      8'hD0:   r = 21'h00011E;
      8'hDD:   r = 21'h000130;
      8'hDE:   r = 21'h00015E;
      8'hF0:   r = 21'h00011F;
      8'hFD:   r = 21'h000131;
      8'hFE:   r = 21'h00015F;
      default: r = {13'd0, b};
    endcase
    return r;
  endfunction

  function automatic uct_pkg::token_t inv_tok(input logic [7:0] b, input logic l5,
                                              input logic last);
    uct_pkg::token_t t;
    t.cp       = l5 ? latin5_cp(b) : uct_pkg::CP_REPL;
    t.replaced = 1'b1;
    t.eot      = 1'b0;
    t.last     = last;
    return t;
  endfunction

  assign h0     = held_r[0];
  assign b_cont = (in_byte[7:6] == 2'b10);
  assign b_lead = in_byte inside {[8'hC0:8'hF7]};

  always_comb begin
    if (h0 inside {[8'hC0:8'hDF]}) begin
      need = 3'd2;
    end else if (h0 inside {[8'hE0:8'hEF]}) begin
      need = 3'd3;
    end else if (h0 inside {[8'hF0:8'hF7]}) begin
      need = 3'd4;
    end else begin
      need = 3'd0;
    end
  end

  always_comb begin
    case (need)
      3'd2: begin
        cp   = {10'd0, h0[4:0], in_byte[5:0]};
        minv = 21'h000080;
      end
      3'd3: begin
        cp   = {5'd0, h0[3:0], held_r[1][5:0], in_byte[5:0]};
        minv = 21'h000800;
      end
      3'd4: begin
        cp   = {h0[2:0], held_r[1][5:0], held_r[2][5:0], in_byte[5:0]};
        minv = 21'h010000;
      end
      default: begin
        cp   = '0;
        minv = '0;
      end
    endcase
  end

  assign complete = (({1'b0, hcnt_r} + 3'd1) == need);
  assign bad      = (cp < minv) || ((cp >= 21'h00D800) && (cp <= 21'h00DFFF)) ||
                    (cp > 21'h10FFFF);

  // Held bytes are a lead and continuations; after a rejected lead the rest
  // drain as stray bytes before the new one, one per cycle unless q_full.
  assign flush = (hcnt_r != 2'd0) &&
                 ((h0[7:6] == 2'b10) || !b_cont || (complete && bad));

  assign in_ready = !q_full && !flush;

  always_comb begin
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    push     = 1'b0;
    push_tok = '0;
    if (in_valid && !q_full) begin
      if (flush) begin
        push        = 1'b1;
        push_tok    = inv_tok(h0, latin5, (hcnt_r == 2'd1) && b_lead);
        held_nxt[0] = held_r[1];
        held_nxt[1] = held_r[2];
        hcnt_nxt    = hcnt_r - 2'd1;
      end else if (hcnt_r == 2'd0) begin
        if (in_byte == 8'h00) begin
          push          = 1'b1;
          push_tok.eot  = 1'b1;
          push_tok.last = 1'b1;
        end else if (!in_byte[7]) begin
          push          = 1'b1;
          push_tok.cp   = {13'd0, in_byte};
          push_tok.last = 1'b1;
        end else if (b_lead) begin
          held_nxt[0] = in_byte;
          hcnt_nxt    = 2'd1;
        end else begin
          push     = 1'b1;
          push_tok = inv_tok(in_byte, latin5, 1'b1);
        end
      end else if (complete) begin
        push          = 1'b1;
        push_tok.cp   = cp;
        push_tok.last = 1'b1;
        hcnt_nxt      = 2'd0;
      end else begin
        held_nxt[hcnt_r] = in_byte;
        hcnt_nxt         = hcnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (!rst_n) begin
      hcnt_r <= 2'd0;
    end else begin
      hcnt_r <= hcnt_nxt;
    end
  end

endmodule

FILE: sv/uct_queue.sv
module uct_queue #(
  parameter int DEPTH = uct_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uct_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output uct_pkg::token_t head_tok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uct_pkg::token_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head_tok = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_tok;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/uct_back.sv
module uct_back (
  input  logic                clk,
  input  logic                rst_n,
  input  uct_pkg::case_mode_t case_mode,
  input  logic                q_nonempty,
  input  uct_pkg::token_t     q_tok,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_replaced,
  output logic                out_end_of_text,
  output logic                out_last_of_run
);

  localparam int W = uct_pkg::CP_W;

  logic [7:0] bbuf_r [4];
  logic [7:0] bbuf_nxt [4];
  logic [2:0] bcnt_r, bcnt_nxt;
  logic       brepl_r, brepl_nxt, beot_r, beot_nxt, blast_r, blast_nxt;

  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       orepl_r, orepl_nxt, oeot_r, oeot_nxt, olast_r, olast_nxt;

  logic [W-1:0] m;
  logic [7:0]   enc [4];
  logic [2:0]   enc_n;
  logic         out_load, buf_free;

  function automatic logic [W-1:0] map_lower(input logic [W-1:0] c);
    logic [W-1:0] r;
    r = c;
    if (c inside {[21'h41:21'h5A]}) begin
      r = (c == 21'h49) ? 21'h131 : c + W'(32);
    end else if (c == 21'h130) begin
      r = 21'h69;
    end else if (c == 21'h11E || c == 21'h15E) begin
      r = c + W'(1);
    end else if (c inside {[21'hC0:21'hDE]} && c != 21'hD7) begin
      r = c + W'(32);
    end
    return r;
  endfunction

  function automatic logic [W-1:0] map_upper(input logic [W-1:0] c);
    logic [W-1:0] r;
    r = c;
    if (c inside {[21'h61:21'h7A]}) begin
      r = (c == 21'h69) ? 21'h130 : c - W'(32);
    end else if (c == 21'h131) begin
      r = 21'h49;
    end else if (c == 21'h11F || c == 21'h15F) begin
      r = c - W'(1);
    end else if (c inside {[21'hE0:21'hFE]} && c != 21'hF7) begin
      r = c - W'(32);
    end
    return r;
  endfunction

  function automatic logic [W-1:0] map_case(input uct_pkg::case_mode_t mode,
                                            input logic [W-1:0] c);
    logic [W-1:0] r;
    case (mode)
      uct_pkg::CASE_LOWER: r = map_lower(c);
      uct_pkg::CASE_UPPER: r = map_upper(c);
      uct_pkg::CASE_FOLD: begin
        r = map_lower(c);
        if (r == 21'h131) begin
          r = 21'h69;
        end
      end
      default: r = c;
    endcase
    return r;
  endfunction

  // U+FFFD and the terminator are left alone by every mapping.
  assign m = map_case(case_mode, q_tok.cp);

  always_comb begin
    enc[0] = '0;
    enc[1] = '0;
    enc[2] = '0;
    enc[3] = '0;
    if (m < 21'h80) begin
      enc_n  = 3'd1;
      enc[0] = m[7:0];
    end else if (m < 21'h800) begin
      enc_n  = 3'd2;
      enc[0] = {3'b110, m[10:6]};
      enc[1] = {2'b10, m[5:0]};
    end else if (m < 21'h10000) begin
      enc_n  = 3'd3;
      enc[0] = {4'b1110, m[15:12]};
      enc[1] = {2'b10, m[11:6]};
      enc[2] = {2'b10, m[5:0]};
    end else begin
      enc_n  = 3'd4;
      enc[0] = {5'b11110, m[20:18]};
      enc[1] = {2'b10, m[17:12]};
      enc[2] = {2'b10, m[11:6]};
      enc[3] = {2'b10, m[5:0]};
    end
  end

  assign out_load = (bcnt_r != 3'd0) && (!ovalid_r || out_ready);
  assign buf_free = (bcnt_r == 3'd0) || ((bcnt_r == 3'd1) && out_load);
  assign q_pop    = q_nonempty && buf_free;

  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    orepl_nxt  = orepl_r;
    oeot_nxt   = oeot_r;
    olast_nxt  = olast_r;
    if (out_load) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = bbuf_r[0];
      orepl_nxt  = brepl_r;
      oeot_nxt   = beot_r;
      olast_nxt  = blast_r && (bcnt_r == 3'd1);
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_comb begin
    bbuf_nxt  = bbuf_r;
    bcnt_nxt  = bcnt_r;
    brepl_nxt = brepl_r;
    beot_nxt  = beot_r;
    blast_nxt = blast_r;
    if (q_pop) begin
      bbuf_nxt  = enc;
      bcnt_nxt  = enc_n;
      brepl_nxt = q_tok.replaced;
      beot_nxt  = q_tok.eot;
      blast_nxt = q_tok.last;
    end else if (out_load) begin
      bbuf_nxt[0] = bbuf_r[1];
      bbuf_nxt[1] = bbuf_r[2];
      bbuf_nxt[2] = bbuf_r[3];
      bcnt_nxt    = bcnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    bbuf_r  <= bbuf_nxt;
    brepl_r <= brepl_nxt;
    beot_r  <= beot_nxt;
    blast_r <= blast_nxt;
    obyte_r <= obyte_nxt;
    orepl_r <= orepl_nxt;
    oeot_r  <= oeot_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      bcnt_r   <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      bcnt_r   <= bcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_replaced    = orepl_r;
  assign out_end_of_text = oeot_r;
  assign out_last_of_run = olast_r;

endmodule

FILE: sv/uct_checker.sv
module uct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_replaced,
  input logic       out_end_of_text,
  input logic       out_last_of_run
);

  // Terminator always closes the request that carried the zero byte.
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_last_of_run)
    else $error("terminator not marked last");

  a_eot_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> (out_byte == 8'h00) && !out_replaced)
    else $error("terminator byte malformed");

  // Substituted text never encodes to a zero byte.
  a_repl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> (out_byte != 8'h00) && !out_end_of_text)
    else $error("replacement byte is zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_run))
    else $error("stalled output changed");

endmodule

bind utf8_case_transcoder uct_checker u_uct_checker (.*);
